[sv/pooled_linked_list_manager_defines.svh]
// ----------------------------------------------------------------------------
// Pooled linked-list manager: assertion macros
// Concurrent check macros for the assertions in the top-level module.
// ----------------------------------------------------------------------------
`ifndef POOLED_LINKED_LIST_MANAGER_DEFINES_SVH
`define POOLED_LINKED_LIST_MANAGER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define PLLM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define PLLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/pllm_pkg.sv]
// ----------------------------------------------------------------------------
// Pooled linked-list manager: package
// Field widths, operation and status codes, and the command/status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package pllm_pkg;

   // Default sizing
   localparam int NODES_DEF     = 256;
   localparam int DATA_BITS_DEF = 32;

   // Payload field widths
   localparam int OP_W     = 3;
   localparam int HEAD_W   = 8;
   localparam int POS_W    = 8;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int SIZE_W   = 8;

   // Longest list that the size field can count
   localparam logic [SIZE_W-1:0] MAX_LEN = 8'd255;

   // Operation codes; codes 6 and 7 are unused
   typedef enum logic [OP_W-1:0] {
      OP_CREATE = 3'd0,
      OP_APPEND = 3'd1,
      OP_INSERT = 3'd2,
      OP_REMOVE = 3'd3,
      OP_GET    = 3'd4,
      OP_SIZE   = 3'd5
   } op_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_POOL  = 2'd2
   } status_type;

   // Datapath micro-operations
   typedef enum logic [3:0] {
      CMD_NONE    = 4'd0,
      CMD_CLEAR   = 4'd1,
      CMD_LOAD    = 4'd2,
      CMD_LEN     = 4'd3,
      CMD_WALK_RD = 4'd4,
      CMD_WALK_WT = 4'd5,
      CMD_FETCH   = 4'd6,
      CMD_GRAB    = 4'd7,
      CMD_POP_RD  = 4'd8,
      CMD_POP_WR  = 4'd9,
      CMD_LINK    = 4'd10,
      CMD_UNLINK  = 4'd11,
      CMD_FREE    = 4'd12,
      CMD_RESULT  = 4'd13
   } dp_cmd_type;

   // Controller to datapath
   typedef struct packed {
      dp_cmd_type cmd;
      status_type code;
   } dp_ctl_type;

   // Datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            clr_last;
      logic            head_bad;
      logic            pos_bad;
      logic            full;
      logic            cnt_zero;
      logic            cur_nil;
      logic            ft_nil;
      logic            out_free;
   } dp_stat_type;

endpackage

[sv/pllm_req_if.sv]
// ----------------------------------------------------------------------------
// Pooled linked-list manager: request channel
// Valid/ready channel carrying one operation request per beat.
// ----------------------------------------------------------------------------
interface pllm_req_if;
   import pllm_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           op;
   logic [HEAD_W-1:0]         list_head;
   logic [POS_W-1:0]          position;
   logic signed [VALUE_W-1:0] value_in;

   modport source (output valid, op, list_head, position, value_in, input ready);
   modport sink   (input valid, op, list_head, position, value_in, output ready);
endinterface

[sv/pllm_rsp_if.sv]
// ----------------------------------------------------------------------------
// Pooled linked-list manager: response channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface pllm_rsp_if;
   import pllm_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [VALUE_W-1:0] value_out;
   logic [HEAD_W-1:0]         new_head;
   logic [SIZE_W-1:0]         size_out;

   modport source (output valid, status, value_out, new_head, size_out, input ready);
   modport sink   (input valid, status, value_out, new_head, size_out, output ready);
endinterface

[sv/pllm_ctrl.sv]
// ----------------------------------------------------------------------------
// Pooled linked-list manager: controller
// One-hot sequencer that steps each operation through the datapath:
// length fetch, link walk, node pop, relink and result.
// ----------------------------------------------------------------------------
module pllm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pllm_pkg::dp_stat_type stat,
   output pllm_pkg::dp_ctl_type  ctl
);
   import pllm_pkg::*;

   typedef enum logic [12:0] {
      S_CLEAR   = 13'b0000000000001,
      S_IDLE    = 13'b0000000000010,
      S_DECODE  = 13'b0000000000100,
      S_CHECK   = 13'b0000000001000,
      S_WALK    = 13'b0000000010000,
      S_WALK_WT = 13'b0000000100000,
      S_GRAB    = 13'b0000001000000,
      S_UNLINK  = 13'b0000010000000,
      S_FREE    = 13'b0000100000000,
      S_POP_RD  = 13'b0001000000000,
      S_POP_WR  = 13'b0010000000000,
      S_LINK    = 13'b0100000000000,
      S_RESULT  = 13'b1000000000000
   } state_type;

   state_type  state_ff, state_in;
   status_type code_ff, code_in;

   // Next state and command
   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      req_ready = 1'b0;
      ctl.cmd   = CMD_NONE;
      ctl.code  = code_ff;
      case (state_ff)
         S_CLEAR: begin
            ctl.cmd = CMD_CLEAR;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.cmd  = CMD_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.op == OP_CREATE) begin
               if (stat.ft_nil) begin
                  code_in  = ST_POOL;
                  state_in = S_RESULT;
               end else begin
                  state_in = S_POP_RD;
               end
            end else if (stat.op inside {[OP_APPEND:OP_SIZE]}) begin
               if (stat.head_bad) begin
                  code_in  = ST_RANGE;
                  state_in = S_RESULT;
               end else begin
                  ctl.cmd  = CMD_LEN;
                  state_in = S_CHECK;
               end
            end else begin
               // unused op: answer with all fields zero
               code_in  = ST_OK;
               state_in = S_RESULT;
            end
         end
         S_CHECK: begin
            if (stat.op == OP_SIZE) begin
               code_in  = ST_OK;
               state_in = S_RESULT;
            end else if (stat.op inside {OP_INSERT, OP_REMOVE, OP_GET} && stat.pos_bad) begin
               code_in  = ST_RANGE;
               state_in = S_RESULT;
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (stat.cur_nil) begin
               // broken chain or walk ended on null
               code_in  = ST_RANGE;
               state_in = S_RESULT;
            end else if (!stat.cnt_zero) begin
               ctl.cmd  = CMD_WALK_RD;
               state_in = S_WALK_WT;
            end else if (stat.op == OP_APPEND) begin
               if (stat.ft_nil || stat.full) begin
                  code_in  = ST_POOL;
                  state_in = S_RESULT;
               end else begin
                  state_in = S_POP_RD;
               end
            end else if (stat.op == OP_INSERT && (stat.ft_nil || stat.full)) begin
               code_in  = ST_POOL;
               state_in = S_RESULT;
            end else begin
               ctl.cmd  = CMD_FETCH;
               state_in = S_GRAB;
            end
         end
         S_WALK_WT: begin
            ctl.cmd  = CMD_WALK_WT;
            state_in = S_WALK;
         end
         S_GRAB: begin
            ctl.cmd = CMD_GRAB;
            if (stat.op == OP_INSERT) begin
               state_in = S_POP_RD;
            end else if (stat.op == OP_REMOVE) begin
               state_in = S_UNLINK;
            end else begin
               code_in  = ST_OK;
               state_in = S_RESULT;
            end
         end
         S_UNLINK: begin
            ctl.cmd  = CMD_UNLINK;
            state_in = S_FREE;
         end
         S_FREE: begin
            ctl.cmd  = CMD_FREE;
            code_in  = ST_OK;
            state_in = S_RESULT;
         end
         S_POP_RD: begin
            ctl.cmd  = CMD_POP_RD;
            state_in = S_POP_WR;
         end
         S_POP_WR: begin
            ctl.cmd = CMD_POP_WR;
            if (stat.op == OP_CREATE) begin
               code_in  = ST_OK;
               state_in = S_RESULT;
            end else begin
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            ctl.cmd  = CMD_LINK;
            code_in  = ST_OK;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            // wait for the output register to drain
            if (stat.out_free) begin
               ctl.cmd  = CMD_RESULT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         code_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

[sv/pllm_dpath.sv]
// ----------------------------------------------------------------------------
// Pooled linked-list manager: datapath
// Link, data and length memories, the free-stack top, walk registers and the
// output register, driven by the controller's micro-operations.
// ----------------------------------------------------------------------------
module pllm_dpath #(
   parameter int NODES     = pllm_pkg::NODES_DEF,
   parameter int DATA_BITS = pllm_pkg::DATA_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pllm_pkg::dp_ctl_type              ctl,
   output pllm_pkg::dp_stat_type             stat,
   input  logic [pllm_pkg::OP_W-1:0]         req_op,
   input  logic [pllm_pkg::HEAD_W-1:0]       req_list_head,
   input  logic [pllm_pkg::POS_W-1:0]        req_position,
   input  logic signed [pllm_pkg::VALUE_W-1:0] req_value_in,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [pllm_pkg::STATUS_W-1:0]     rsp_status,
   output logic signed [pllm_pkg::VALUE_W-1:0] rsp_value_out,
   output logic [pllm_pkg::HEAD_W-1:0]       rsp_new_head,
   output logic [pllm_pkg::SIZE_W-1:0]       rsp_size_out
);
   import pllm_pkg::*;

   localparam int IW = $clog2(NODES);
   localparam int LW = $clog2(NODES + 1);
   localparam logic [LW-1:0] NIL      = LW'(NODES);
   localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);

   // Memories
   logic [LW-1:0]        next_mem [NODES];
   logic [LW-1:0]        prev_mem [NODES];
   logic [DATA_BITS-1:0] data_mem [NODES];
   logic [SIZE_W-1:0]    len_mem  [NODES];

   logic [LW-1:0]        next_rd_ff, prev_rd_ff;
   logic [DATA_BITS-1:0] data_rd_ff;
   logic [SIZE_W-1:0]    len_rd_ff;

   // Latched request
   logic [OP_W-1:0]      op_ff;
   logic [HEAD_W-1:0]    head_ff;
   logic [POS_W-1:0]     pos_ff;
   logic [DATA_BITS-1:0] val_ff;

   // Work registers
   logic [LW-1:0]              cur_ff, nx_ff, pr_ff, ft_ff;
   logic [IW-1:0]              n_ff, clr_ff;
   logic [SIZE_W-1:0]          len_ff, cnt_ff;
   logic signed [VALUE_W-1:0]  vout_ff;

   // Output register
   logic                       rsp_valid_ff;
   logic [STATUS_W-1:0]        status_ff;
   logic signed [VALUE_W-1:0]  value_ff;
   logic [HEAD_W-1:0]          new_head_ff;
   logic [SIZE_W-1:0]          size_ff;

   // Memory port signals
   logic [IW-1:0]        next_raddr, len_raddr;
   logic                 next_we, prev_we, data_we, len_we;
   logic [IW-1:0]        next_waddr, prev_waddr, len_waddr;
   logic [LW-1:0]        next_wdata, prev_wdata;
   logic [SIZE_W-1:0]    len_wdata;

   logic [IW-1:0]        cur_idx, ft_idx, head_idx;
   logic                 head_bad, res_ok;

   assign cur_idx  = cur_ff[IW-1:0];
   assign ft_idx   = ft_ff[IW-1:0];
   assign head_idx = IW'(head_ff);
   assign head_bad = 32'(head_ff) >= 32'(NODES);
   assign res_ok   = ctl.code == ST_OK;

   // Status to the controller
   assign stat.op       = op_ff;
   assign stat.clr_last = clr_ff == LAST_IDX;
   assign stat.head_bad = head_bad;
   assign stat.pos_bad  = pos_ff >= len_ff;
   assign stat.full     = len_ff == MAX_LEN;
   assign stat.cnt_zero = cnt_ff == '0;
   assign stat.cur_nil  = cur_ff >= NIL;
   assign stat.ft_nil   = ft_ff >= NIL;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   // Read addresses
   assign next_raddr = (ctl.cmd == CMD_POP_RD) ? ft_idx : cur_idx;
   assign len_raddr  = (ctl.cmd == CMD_LOAD) ? IW'(req_list_head) : head_idx;

   // Write ports per micro-operation
   always_comb begin
      next_we    = 1'b0;
      next_waddr = cur_idx;
      next_wdata = NIL;
      prev_we    = 1'b0;
      prev_waddr = cur_idx;
      prev_wdata = NIL;
      data_we    = 1'b0;
      len_we     = 1'b0;
      len_waddr  = head_idx;
      len_wdata  = '0;
      case (ctl.cmd)
         CMD_CLEAR: begin
            // initial free chain: i -> i+1, last -> null
            next_we    = 1'b1;
            next_waddr = clr_ff;
            next_wdata = LW'(clr_ff) + LW'(1);
            prev_we    = 1'b1;
            prev_waddr = clr_ff;
         end
         CMD_POP_WR: begin
            next_we    = 1'b1;
            next_waddr = ft_idx;
            next_wdata = (op_ff == OP_INSERT) ? nx_ff : NIL;
            prev_we    = 1'b1;
            prev_waddr = ft_idx;
            prev_wdata = (op_ff == OP_CREATE) ? NIL : cur_ff;
            data_we    = op_ff != OP_CREATE;
            len_we     = op_ff == OP_CREATE;
            len_waddr  = ft_idx;
         end
         CMD_LINK: begin
            next_we    = 1'b1;
            next_wdata = LW'(n_ff);
            prev_we    = (op_ff == OP_INSERT) && (nx_ff < NIL);
            prev_waddr = nx_ff[IW-1:0];
            prev_wdata = LW'(n_ff);
            len_we     = 1'b1;
            len_wdata  = len_ff + 8'd1;
         end
         CMD_UNLINK: begin
            next_we    = pr_ff < NIL;
            next_waddr = pr_ff[IW-1:0];
            next_wdata = nx_ff;
            prev_we    = nx_ff < NIL;
            prev_waddr = nx_ff[IW-1:0];
            prev_wdata = pr_ff;
         end
         CMD_FREE: begin
            // push the removed node on the free stack
            next_we    = 1'b1;
            next_wdata = ft_ff;
            prev_we    = 1'b1;
            len_we     = 1'b1;
            len_wdata  = len_ff - 8'd1;
         end
         default: begin
         end
      endcase
   end

   // Link memories
   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      next_rd_ff <= next_mem[next_raddr];
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      prev_rd_ff <= prev_mem[cur_idx];
   end

   // Data and length memories
   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[ft_idx] <= val_ff;
      end
      data_rd_ff <= data_mem[cur_idx];
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
      len_rd_ff <= len_mem[len_raddr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ft_ff        <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.cmd == CMD_CLEAR) begin
            clr_ff <= clr_ff + IW'(1);
         end
         if (ctl.cmd == CMD_POP_WR) begin
            ft_ff <= next_rd_ff;
         end else if (ctl.cmd == CMD_FREE) begin
            ft_ff <= cur_ff;
         end
         if (ctl.cmd == CMD_RESULT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload and work registers
   always_ff @(posedge clock) begin
      case (ctl.cmd)
         CMD_LOAD: begin
            op_ff   <= req_op;
            head_ff <= req_list_head;
            pos_ff  <= req_position;
            val_ff  <= DATA_BITS'($unsigned(req_value_in));
         end
         CMD_LEN: begin
            // append walks len links from the head, others pos+1
            len_ff <= len_rd_ff;
            cur_ff <= LW'(head_ff);
            cnt_ff <= (op_ff == OP_APPEND) ? len_rd_ff : pos_ff + 8'd1;
         end
         CMD_WALK_WT: begin
            cur_ff <= next_rd_ff;
            cnt_ff <= cnt_ff - 8'd1;
         end
         CMD_GRAB: begin
            nx_ff   <= next_rd_ff;
            pr_ff   <= prev_rd_ff;
            vout_ff <= VALUE_W'($signed(data_rd_ff));
         end
         CMD_POP_WR: begin
            n_ff <= ft_idx;
         end
         CMD_LINK: begin
            len_ff <= len_ff + 8'd1;
         end
         CMD_FREE: begin
            len_ff <= len_ff - 8'd1;
         end
         CMD_RESULT: begin
            status_ff   <= ctl.code;
            value_ff    <= (res_ok && (op_ff == OP_GET || op_ff == OP_REMOVE)) ?
                           vout_ff : '0;
            new_head_ff <= (res_ok && op_ff == OP_CREATE) ? HEAD_W'(n_ff) : '0;
            size_ff     <= (op_ff inside {[OP_APPEND:OP_SIZE]} && !head_bad) ?
                           len_ff : '0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_value_out = value_ff;
   assign rsp_new_head  = new_head_ff;
   assign rsp_size_out  = size_ff;

endmodule

[sv/pooled_linked_list_manager.sv]
// ----------------------------------------------------------------------------
// Pooled linked-list manager
// Shared node pool with doubly linked lists named by sentinel heads and a
// free stack chained through the next links.
//
//   Channel  Dir  Handshake    Beat contents
//   req_ch   in   valid/ready  op, list_head, position, value_in
//   rsp_ch   out  valid/ready  status, value_out, new_head, size_out
//
// After reset a clearing pass over all NODES nodes builds the free chain;
// no request is taken during it. Ready returns once an accepted beat has
// been sequenced to its result, including any link walk (one registered
// next-link read per step); a walk covers no more links than the list holds.
// The result beat shows as ready returns; the next request is taken while it
// waits, and a new result is held back only while the old one is unaccepted.
// ----------------------------------------------------------------------------
`include "pooled_linked_list_manager_defines.svh"

module pooled_linked_list_manager #(
   parameter int NODES     = pllm_pkg::NODES_DEF,
   parameter int DATA_BITS = pllm_pkg::DATA_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   pllm_req_if.sink   req_ch,
   pllm_rsp_if.source rsp_ch
);
   import pllm_pkg::*;

   dp_ctl_type  ctl;
   dp_stat_type stat;

   // Sequencer
   pllm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // Memories and registers
   pllm_dpath #(
      .NODES     (NODES),
      .DATA_BITS (DATA_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .stat          (stat),
      .req_op        (req_ch.op),
      .req_list_head (req_ch.list_head),
      .req_position  (req_ch.position),
      .req_value_in  (req_ch.value_in),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_status    (rsp_ch.status),
      .rsp_value_out (rsp_ch.value_out),
      .rsp_new_head  (rsp_ch.new_head),
      .rsp_size_out  (rsp_ch.size_out)
   );

   // Checks
   `PLLM_ASSERT_IMPL(a_accept_loads, clock, reset, req_ch.valid && req_ch.ready,
      ctl.cmd == CMD_LOAD, "request beat taken without a load")
   `PLLM_ASSERT_IMPL(a_result_slot_free, clock, reset, ctl.cmd == CMD_RESULT,
      stat.out_free, "result written over a pending beat")
   `PLLM_ASSERT_IMPL(a_pop_nonempty, clock, reset, ctl.cmd == CMD_POP_RD,
      !stat.ft_nil, "pop from an empty free stack")
   `PLLM_ASSERT_IMPL(a_walk_live, clock, reset, ctl.cmd == CMD_WALK_RD,
      !stat.cur_nil && !stat.cnt_zero, "walk step on null or finished walk")
   `PLLM_ASSERT_NEXT(a_result_shown, clock, reset, ctl.cmd == CMD_RESULT,
      rsp_ch.valid, "result not presented after write")

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pooled linked-list manager: testbench
// Issues list operations over the request channel and checks every result
// beat against a predictor of the node pool, its free stack and the lists it
// holds. A short directed part covers empty lists, head and tail edits, bad
// positions and unused ops. A fill phase then exhausts the pool through one
// list. Random batches follow, shaped to grow and shrink the lists.
// ----------------------------------------------------------------------------
module tb_top;
   import pllm_pkg::*;

   localparam int             POOL_NODES   = NODES_DEF;
   localparam logic [8:0]     NULL_LINK    = 9'(POOL_NODES);
   localparam logic [OP_W-1:0] OP_SPARE_A  = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B  = 3'd7;
   localparam int             RANDOM_ITEMS = 1250;
   localparam int             MAX_LISTS    = 12;
   localparam int             DRAIN_CYCLES = 2 * POOL_NODES + 80;
   localparam int             CYCLE_LIMIT  = 4_000_000;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [HEAD_W-1:0]  head;
      logic [POS_W-1:0]   pos;
      logic [VALUE_W-1:0] value;
   } list_cmd_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  value;
      logic [HEAD_W-1:0]   new_head;
      logic [SIZE_W-1:0]   count;
   } list_rsp_type;

   logic clock = 1'b0;
   logic reset;

   pllm_req_if req_ch ();
   pllm_rsp_if rsp_ch ();

   pooled_linked_list_manager i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Pool image: links, data words, free stack top, element counts
   logic [8:0]         link_fwd   [POOL_NODES];
   logic [8:0]         link_back  [POOL_NODES];
   logic [VALUE_W-1:0] node_word  [POOL_NODES];
   logic [SIZE_W-1:0]  elem_count [POOL_NODES];
   logic [8:0]         free_head;
   logic [HEAD_W-1:0]  list_heads [$];

   list_cmd_type cmd_queue [$];
   list_rsp_type rsp_queue [$];
   list_cmd_type cur_cmd;
   bit           cmd_in_flight;

   int mismatches;
   int cycles;
   int items_done;
   int status_seen [4];
   int longest_list;

   function automatic void clear_pool();
      for (int i = 0; i < POOL_NODES; i++) begin
         link_fwd[i]   = 9'(i + 1);
         link_back[i]  = NULL_LINK;
         node_word[i]  = '0;
         elem_count[i] = '0;
      end
      free_head = '0;
   endfunction

   // Follow forward links; null once a null link is met
   function automatic logic [8:0] follow_links(logic [8:0] start, int steps);
      logic [8:0] cur;
      cur = start;
      for (int i = 0; i < steps; i++) begin
         if (cur >= NULL_LINK) return NULL_LINK;
         cur = link_fwd[cur[7:0]];
      end
      return cur;
   endfunction

   function automatic logic [8:0] take_free_node();
      logic [8:0] n;
      n = free_head;
      free_head          = link_fwd[n[7:0]];
      link_fwd[n[7:0]]   = NULL_LINK;
      link_back[n[7:0]]  = NULL_LINK;
      return n;
   endfunction

   // Applies one operation to the pool image and returns its result beat
   function automatic list_rsp_type apply_list_op(list_cmd_type c);
      list_rsp_type r;
      int           len;
      logic [8:0]   e, n, pr, nx;
      r = '{status: ST_OK, value: '0, new_head: '0, count: '0};
      if (c.op == OP_CREATE) begin
         if (free_head >= NULL_LINK) begin
            r.status = ST_POOL;
         end else begin
            n = take_free_node();
            elem_count[n[7:0]] = '0;
            r.new_head = n[7:0];
            list_heads.push_back(n[7:0]);
         end
      end else if (c.op <= OP_SIZE) begin
         len = elem_count[c.head];
         if (c.op == OP_APPEND) begin
            e = follow_links(9'(c.head), len);
            if (e >= NULL_LINK) begin
               r.status = ST_RANGE;
            end else if (free_head >= NULL_LINK || len >= MAX_LEN) begin
               r.status = ST_POOL;
            end else begin
               n = take_free_node();
               link_fwd[e[7:0]]  = n;
               link_back[n[7:0]] = e;
               node_word[n[7:0]] = c.value;
               len++;
            end
         end else if (c.op != OP_SIZE) begin
            e = (c.pos < len) ? follow_links(link_fwd[c.head], c.pos) : NULL_LINK;
            if (e >= NULL_LINK) begin
               r.status = ST_RANGE;
            end else if (c.op == OP_INSERT) begin
               if (free_head >= NULL_LINK || len >= MAX_LEN) begin
                  r.status = ST_POOL;
               end else begin
                  nx = link_fwd[e[7:0]];
                  n  = take_free_node();
                  link_back[n[7:0]] = e;
                  link_fwd[n[7:0]]  = nx;
                  link_fwd[e[7:0]]  = n;
                  if (nx < NULL_LINK) link_back[nx[7:0]] = n;
                  node_word[n[7:0]] = c.value;
                  len++;
               end
            end else if (c.op == OP_REMOVE) begin
               pr = link_back[e[7:0]];
               nx = link_fwd[e[7:0]];
               if (pr < NULL_LINK) link_fwd[pr[7:0]] = nx;
               if (nx < NULL_LINK) link_back[nx[7:0]] = pr;
               r.value           = node_word[e[7:0]];
               link_fwd[e[7:0]]  = free_head;
               link_back[e[7:0]] = NULL_LINK;
               free_head         = e;
               len--;
            end else begin
               r.value = node_word[e[7:0]];
            end
         end
         elem_count[c.head] = 8'(len);
         r.count = 8'(len);
         if (len > longest_list) longest_list = len;
      end
      status_seen[r.status]++;
      return r;
   endfunction

   function automatic void queue_cmd(logic [OP_W-1:0] op, logic [HEAD_W-1:0] head,
                                     logic [POS_W-1:0] pos, logic [VALUE_W-1:0] value);
      cmd_queue.push_back('{op: op, head: head, pos: pos, value: value});
   endfunction

   function automatic void check_field(string name, logic [VALUE_W-1:0] exp_v,
                                       logic [VALUE_W-1:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   // Waits until every queued request has been answered
   task automatic drain();
      @(posedge clock);
      while (cmd_queue.size() != 0 || cmd_in_flight || rsp_queue.size() != 0)
         @(posedge clock);
   endtask

   // Request driver: bursts of beats separated by random gaps
   int burst_left;
   int gap_left;

   always @(posedge clock) begin : drv
      if (reset) begin
         req_ch.valid  <= 1'b0;
         burst_left    = 0;
         gap_left      = 0;
         cmd_in_flight = 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            rsp_queue.push_back(apply_list_op(cur_cmd));
            cmd_in_flight = 1'b0;
            items_done++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
               cur_cmd       = cmd_queue.pop_front();
               cmd_in_flight = 1'b1;
               req_ch.valid     <= 1'b1;
               req_ch.op        <= cur_cmd.op;
               req_ch.list_head <= cur_cmd.head;
               req_ch.position  <= cur_cmd.pos;
               req_ch.value_in  <= cur_cmd.value;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Result stalls: a stall mode is drawn at random and redrawn when its countdown runs out
   int stall_mode;
   int stall_left;
   int mode_left;

   always @(posedge clock) begin : stall
      if (reset) begin
         rsp_ch.ready <= 1'b1;
         stall_mode = 0;
         stall_left = 0;
         mode_left  = 0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(200, 900);
         end else begin
            mode_left--;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_mode == 1) begin
            rsp_ch.ready <= ($urandom_range(0, 2) != 0);
         end else if (stall_mode == 2 && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 24);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Result monitor: each beat against the oldest expectation
   always @(posedge clock) begin : mon
      list_rsp_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (rsp_queue.size() == 0) begin
            $error("result beat with no request outstanding");
            mismatches++;
         end else begin
            exp_r = rsp_queue.pop_front();
            check_field("status", exp_r.status, rsp_ch.status);
            check_field("value_out", exp_r.value, rsp_ch.value_out);
            check_field("new_head", exp_r.new_head, rsp_ch.new_head);
            check_field("size_out", exp_r.count, rsp_ch.size_out);
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin : stim
      logic [HEAD_W-1:0] h;
      logic [POS_W-1:0]  p;
      logic [OP_W-1:0]   op;
      int                issued;
      int                batch;
      int                mode;
      int                len;
      int                r;

      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.op        = '0;
      req_ch.list_head = '0;
      req_ch.position  = '0;
      req_ch.value_in  = '0;
      rsp_ch.ready     = 1'b0;
      mismatches   = 0;
      cycles       = 0;
      items_done   = 0;
      longest_list = 0;
      clear_pool();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty list, value extremes, head/tail edits, bad positions
      queue_cmd(OP_CREATE, 8'hA5, '0, '0);
      drain();
      h = list_heads[0];
      queue_cmd(OP_INSERT, h, 8'd0, 32'h1234_5678);
      queue_cmd(OP_GET,    h, 8'd0, '0);
      queue_cmd(OP_REMOVE, h, 8'd0, '0);
      queue_cmd(OP_SIZE,   h, 8'd0, '0);
      queue_cmd(OP_APPEND, h, 8'd0, 32'h7FFF_FFFF);
      queue_cmd(OP_APPEND, h, 8'd0, 32'h8000_0000);
      queue_cmd(OP_APPEND, h, 8'd0, 32'h0000_0000);
      queue_cmd(OP_APPEND, h, 8'd0, 32'hFFFF_FFFF);
      queue_cmd(OP_INSERT, h, 8'd0, 32'h0000_0001);
      queue_cmd(OP_INSERT, h, 8'd4, 32'h5555_5555);
      queue_cmd(OP_GET,    h, 8'd0, '0);
      queue_cmd(OP_GET,    h, 8'd5, '0);
      queue_cmd(OP_GET,    h, 8'd6, '0);
      queue_cmd(OP_GET,    h, 8'd255, '0);
      queue_cmd(OP_REMOVE, h, 8'd5, '0);
      queue_cmd(OP_REMOVE, h, 8'd0, '0);
      queue_cmd(OP_REMOVE, h, 8'd1, '0);
      queue_cmd(OP_SPARE_A, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      queue_cmd(OP_SPARE_B, 8'h5A, 8'h3C, $urandom);
      queue_cmd(OP_INSERT, h, 8'd255, 32'hAAAA_AAAA);
      queue_cmd(OP_SIZE,   h, 8'd0, '0);
      drain();

      // Fill one list until both the pool and its count are exhausted
      issued = 0;
      len = MAX_LEN - elem_count[h] + 1;
      for (int k = 0; k < len; k++) queue_cmd(OP_APPEND, h, 8'($urandom), $urandom);
      queue_cmd(OP_INSERT, h, 8'($urandom_range(0, 254)), $urandom);
      queue_cmd(OP_CREATE, 8'($urandom), 8'($urandom), $urandom);
      issued += len + 2;
      drain();

      // Random batches, each biased toward growth, shrinkage or a mix
      while (issued < RANDOM_ITEMS) begin
         mode  = $urandom_range(0, 2);
         batch = $urandom_range(8, 40);
         for (int k = 0; k < batch; k++) begin
            r = $urandom_range(0, 99);
            if (r < 4 && list_heads.size() < MAX_LISTS) begin
               queue_cmd(OP_CREATE, 8'($urandom), 8'($urandom), $urandom);
               continue;
            end
            if (r < 7) begin
               op = ($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B;
               queue_cmd(op, 8'($urandom), 8'($urandom), $urandom);
               continue;
            end
            h   = list_heads[$urandom_range(0, list_heads.size() - 1)];
            len = elem_count[h];
            r   = $urandom_range(0, 99);
            case (mode)
               0:       op = (r < 40) ? OP_APPEND : (r < 70) ? OP_INSERT :
                             (r < 80) ? OP_REMOVE : (r < 92) ? OP_GET : OP_SIZE;
               1:       op = (r < 10) ? OP_APPEND : (r < 20) ? OP_INSERT :
                             (r < 70) ? OP_REMOVE : (r < 90) ? OP_GET : OP_SIZE;
               default: op = (r < 25) ? OP_APPEND : (r < 45) ? OP_INSERT :
                             (r < 70) ? OP_REMOVE : (r < 90) ? OP_GET : OP_SIZE;
            endcase
            // Mostly in-range positions, with tail, one-past-end and wild picks
            case ($urandom_range(0, 7))
               0:       p = 8'($urandom);
               1:       p = 8'(len);
               2:       p = (len > 0) ? 8'(len - 1) : 8'd0;
               default: p = (len > 0) ? 8'($urandom_range(0, len - 1)) : 8'd0;
            endcase
            queue_cmd(op, h, p, $urandom);
         end
         issued += batch;
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d requests: %0d ok, %0d out of range, %0d pool empty.",
               items_done, status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_POOL]);
      $display("Lists created: %0d, longest list reached %0d elements.",
               list_heads.size(), longest_list);
      if (mismatches == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/pllm_pkg.sv
sv/pllm_req_if.sv
sv/pllm_rsp_if.sv
sv/pllm_ctrl.sv
sv/pllm_dpath.sv
sv/pooled_linked_list_manager.sv
test/tb_top.sv
